[hdl/sirt_pkg.sv]
// ----------------------------------------------------------------------------
// Signed integer to radix text: shared package
// Widths, constants, register codes, controller states and the command and
// status words between the controller and the datapath.
// ----------------------------------------------------------------------------
package sirt_pkg;

  localparam int MAX_RADIX     = 16;
  localparam int DIGIT_DEPTH   = 32;
  localparam int VALUE_W       = 32;
  localparam int CHAR_W        = 8;
  localparam int RADIX_W       = 5;
  localparam int CFG_DATA_W    = 64;
  localparam int CFG_ADDR_W    = 5;
  localparam int NUM_SYMS      = 2 * CFG_DATA_W / CHAR_W;
  localparam int SYM_IDX_W     = $clog2(NUM_SYMS);
  localparam int DIGIT_W       = $clog2(MAX_RADIX);
  localparam int REM_W         = DIGIT_W + 1;
  localparam int IDX_W         = $clog2(DIGIT_DEPTH);
  localparam int CNT_W         = IDX_W + 1;
  localparam int BITS_PER_STEP = 8;
  localparam int DIV_STEPS     = VALUE_W / BITS_PER_STEP;
  localparam int STEP_W        = $clog2(DIV_STEPS);

  localparam logic [RADIX_W-1:0]    RADIX_RESET    = RADIX_W'(10);
  localparam logic [CFG_DATA_W-1:0] ALPHA_LO_RESET = 64'h3736_3534_3332_3130;
  localparam logic [CFG_DATA_W-1:0] ALPHA_HI_RESET = 64'h0000_0000_6463_6261;

  localparam logic [CHAR_W-1:0] SYM_MIN    = 8'd47;
  localparam logic [CHAR_W-1:0] GAP1_LO    = 8'd58;
  localparam logic [CHAR_W-1:0] GAP1_HI    = 8'd64;
  localparam logic [CHAR_W-1:0] GAP2_LO    = 8'd91;
  localparam logic [CHAR_W-1:0] GAP2_HI    = 8'd96;
  localparam logic [CHAR_W-1:0] SYM_MAX    = 8'd123;
  localparam logic [CHAR_W-1:0] MINUS_SIGN = 8'h2D;
  localparam logic [CHAR_W-1:0] ERR_CHAR   = 8'h00;

  typedef enum logic [1:0] {
    REG_RADIX    = 2'd0,
    REG_ALPHA_LO = 2'd1,
    REG_ALPHA_HI = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_SIGN,
    S_EMIT,
    S_ERR
  } state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic emit_sign;
    logic emit_digit;
    logic emit_err;
  } cmd_t;

  typedef struct packed {
    logic alph_ok;
    logic neg;
    logic div_final;
    logic slot_free;
    logic digit_last;
  } sts_t;

  function automatic logic symbol_ok(input logic [CHAR_W-1:0] s);
    return !((s < SYM_MIN) || ((s > GAP1_LO) && (s < GAP1_HI)) ||
             ((s > GAP2_LO) && (s < GAP2_HI)) || (s > SYM_MAX));
  endfunction

  function automatic logic [CHAR_W-1:0] sym_at(input logic [2*CFG_DATA_W-1:0] w,
                                                input logic [SYM_IDX_W-1:0] k);
    return w[k*CHAR_W +: CHAR_W];
  endfunction

endpackage

[hdl/sirt_if.sv]
// ----------------------------------------------------------------------------
// Signed integer to radix text: channel interfaces
// Valid/ready channels for the input value and for the character words.
// ----------------------------------------------------------------------------
interface sirt_in_if import sirt_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

interface sirt_out_if import sirt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;
  logic              base_error;

  modport source (output valid, output character, output last, output base_error,
                  input ready);
  modport sink (input valid, input character, input last, input base_error,
                output ready);
endinterface

[hdl/sirt_cfg.sv]
// ----------------------------------------------------------------------------
// Signed integer to radix text: configuration registers
// APB-style register file holding the radix and the alphabet, with a
// registered validity check of the alphabet.
// ----------------------------------------------------------------------------
module sirt_cfg import sirt_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CFG_ADDR_W-1:0]   paddr,
  input  logic [CFG_DATA_W-1:0]   pwdata,
  output logic [CFG_DATA_W-1:0]   prdata,
  output logic                    pready,
  output logic [RADIX_W-1:0]      radix,
  output logic [2*CFG_DATA_W-1:0] alphabet,
  output logic                    alph_ok
);

  logic [RADIX_W-1:0]    radix_r;
  logic [CFG_DATA_W-1:0] alpha_lo_r;
  logic [CFG_DATA_W-1:0] alpha_hi_r;
  logic                  alph_ok_r;
  logic                  alph_ok_nxt;
  logic                  wr_en;
  reg_idx_t              idx;

  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite;
  assign idx      = reg_idx_t'(paddr[CFG_ADDR_W-1:3]);
  assign radix    = radix_r;
  assign alphabet = {alpha_hi_r, alpha_lo_r};
  assign alph_ok  = alph_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r    <= RADIX_RESET;
      alpha_lo_r <= ALPHA_LO_RESET;
      alpha_hi_r <= ALPHA_HI_RESET;
      alph_ok_r  <= 1'b0;
    end else begin
      alph_ok_r <= alph_ok_nxt;
      if (wr_en) begin
        case (idx)
          REG_RADIX:    radix_r    <= pwdata[RADIX_W-1:0];
          REG_ALPHA_LO: alpha_lo_r <= pwdata;
          REG_ALPHA_HI: alpha_hi_r <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_RADIX:    prdata = CFG_DATA_W'(radix_r);
      REG_ALPHA_LO: prdata = alpha_lo_r;
      REG_ALPHA_HI: prdata = alpha_hi_r;
      default:      prdata = '0;
    endcase
  end

  // Every symbol in use must pass the range test and appear only once.
  always_comb begin
    logic bad;
    bad = (radix_r < RADIX_W'(2)) || (radix_r > RADIX_W'(MAX_RADIX));
    for (int i = 0; i < NUM_SYMS; i++) begin
      if (RADIX_W'(i) < radix_r) begin
        if (!symbol_ok(sym_at(alphabet, SYM_IDX_W'(i)))) begin
          bad = 1'b1;
        end
        for (int j = i + 1; j < NUM_SYMS; j++) begin
          if ((RADIX_W'(j) < radix_r) &&
              (sym_at(alphabet, SYM_IDX_W'(i)) == sym_at(alphabet, SYM_IDX_W'(j)))) begin
            bad = 1'b1;
          end
        end
      end
    end
    alph_ok_nxt = !bad;
  end

endmodule

[hdl/sirt_dp.sv]
// ----------------------------------------------------------------------------
// Signed integer to radix text: datapath
// Magnitude register with a radix divider that retires several quotient bits
// a cycle, the digit store, and the output word register.
// ----------------------------------------------------------------------------
module sirt_dp import sirt_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  logic signed [VALUE_W-1:0] in_value,
  input  logic [RADIX_W-1:0]        radix,
  input  logic [2*CFG_DATA_W-1:0]   alphabet,
  input  logic                      alph_ok,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CHAR_W-1:0]         out_character,
  output logic                      out_last,
  output logic                      out_base_error
);

  logic                     neg_r;
  logic [VALUE_W-1:0]       mag_r;
  logic [VALUE_W-1:0]       mag_nxt;
  logic [DIGIT_W-1:0]       rem_r;
  logic [DIGIT_W-1:0]       rem_div;
  logic [BITS_PER_STEP-1:0] quo_bits;
  logic [STEP_W-1:0]        step_r;
  logic [CNT_W-1:0]         cnt_r;
  logic [CNT_W-1:0]         cnt_dec;
  logic                     chunk_last;
  logic [DIGIT_W-1:0]       store_r [DIGIT_DEPTH];
  logic                     out_valid_r;
  logic [CHAR_W-1:0]        out_char_r;
  logic                     out_last_r;
  logic                     out_err_r;
  logic                     emit;

  // Restoring division of the magnitude by the radix, a chunk of bits a cycle.
  always_comb begin
    logic [DIGIT_W-1:0] r;
    logic [REM_W-1:0]   t;
    r = rem_r;
    for (int k = 0; k < BITS_PER_STEP; k++) begin
      t = {r, mag_r[VALUE_W-1-k]};
      if (RADIX_W'(t) >= radix) begin
        r = DIGIT_W'(RADIX_W'(t) - radix);
        quo_bits[BITS_PER_STEP-1-k] = 1'b1;
      end else begin
        r = t[DIGIT_W-1:0];
        quo_bits[BITS_PER_STEP-1-k] = 1'b0;
      end
    end
    rem_div = r;
    mag_nxt = {mag_r[VALUE_W-BITS_PER_STEP-1:0], quo_bits};
  end

  assign chunk_last = (step_r == STEP_W'(DIV_STEPS - 1));
  assign cnt_dec    = cnt_r - CNT_W'(1);
  assign emit       = cmd.emit_sign | cmd.emit_digit | cmd.emit_err;

  assign sts.alph_ok    = alph_ok;
  assign sts.neg        = neg_r;
  assign sts.div_final  = chunk_last &&
                          ((mag_nxt == '0) || (cnt_r == CNT_W'(DIGIT_DEPTH - 1)));
  assign sts.slot_free  = !out_valid_r || out_ready;
  assign sts.digit_last = (cnt_r == CNT_W'(1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      neg_r       <= 1'b0;
      mag_r       <= '0;
      rem_r       <= '0;
      step_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        neg_r  <= in_value[VALUE_W-1];
        mag_r  <= in_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(in_value))
                                      : VALUE_W'(in_value);
        rem_r  <= '0;
        step_r <= '0;
        cnt_r  <= '0;
      end else if (cmd.div_step) begin
        mag_r  <= mag_nxt;
        step_r <= step_r + STEP_W'(1);
        rem_r  <= chunk_last ? '0 : rem_div;
        if (chunk_last) begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end else if (cmd.emit_digit) begin
        cnt_r <= cnt_dec;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_step && chunk_last) begin
      store_r[cnt_r[IDX_W-1:0]] <= rem_div;
    end
    if (cmd.emit_sign) begin
      out_char_r <= MINUS_SIGN;
      out_last_r <= 1'b0;
      out_err_r  <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_char_r <= sym_at(alphabet, SYM_IDX_W'(store_r[cnt_dec[IDX_W-1:0]]));
      out_last_r <= (cnt_r == CNT_W'(1));
      out_err_r  <= 1'b0;
    end else if (cmd.emit_err) begin
      out_char_r <= ERR_CHAR;
      out_last_r <= 1'b1;
      out_err_r  <= 1'b1;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_character  = out_char_r;
  assign out_last       = out_last_r;
  assign out_base_error = out_err_r;

endmodule

[hdl/sirt_ctrl.sv]
// ----------------------------------------------------------------------------
// Signed integer to radix text: controller
// State machine that sequences the check, the division and the emission of
// the character words.
// ----------------------------------------------------------------------------
module sirt_ctrl import sirt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        state_nxt = sts.alph_ok ? S_DIV : S_ERR;
      end
      S_DIV: begin
        if (sts.div_final) state_nxt = sts.neg ? S_SIGN : S_EMIT;
      end
      S_SIGN: begin
        if (sts.slot_free) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.slot_free && sts.digit_last) state_nxt = S_IDLE;
      end
      S_ERR: begin
        if (sts.slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK: ;
      S_DIV:   cmd.div_step   = 1'b1;
      S_SIGN:  cmd.emit_sign  = sts.slot_free;
      S_EMIT:  cmd.emit_digit = sts.slot_free;
      S_ERR:   cmd.emit_err   = sts.slot_free;
      default: ;
    endcase
  end

endmodule

[hdl/signed_integer_to_radix_text_top.sv]
// ----------------------------------------------------------------------------
// Signed integer to radix text: top level
// Prints each signed 32-bit value as characters in the configured radix.
// ----------------------------------------------------------------------------
// Each accepted value becomes a run of character words, a minus sign first
// for a negative value and then the digits, most significant first, each
// mapped through the configured alphabet; the final word carries last. If the
// radix or the alphabet is invalid, a single word with base_error set is sent.
// One value is handled at a time. The radix divider retires eight quotient
// bits a cycle; all digits are found before the first character word is sent.
module signed_integer_to_radix_text_top import sirt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  sirt_in_if.sink               in_ch,
  sirt_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [RADIX_W-1:0]      radix;
  logic [2*CFG_DATA_W-1:0] alphabet;
  logic                    alph_ok;
  cmd_t                    cmd;
  sts_t                    sts;

  sirt_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .radix    (radix),
    .alphabet (alphabet),
    .alph_ok  (alph_ok)
  );

  sirt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sirt_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_value       (in_ch.value),
    .radix          (radix),
    .alphabet       (alphabet),
    .alph_ok        (alph_ok),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_character  (out_ch.character),
    .out_last       (out_ch.last),
    .out_base_error (out_ch.base_error)
  );

endmodule

[hdl/sirt_checker.sv]
// ----------------------------------------------------------------------------
// Signed integer to radix text: port checker
// Concurrent assertions on the top-level channels, bound to the top level.
// ----------------------------------------------------------------------------
module sirt_checker import sirt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] out_character,
  input logic              out_last,
  input logic              out_base_error
);

  // A word waiting to be taken holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_character) &&
                                $stable(out_last) && $stable(out_base_error))
    else $error("output word changed while stalled");

  // The error word is always a lone final word with a null character.
  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_base_error |-> out_last && (out_character == ERR_CHAR))
    else $error("malformed error word");

  // A minus sign always leads digits, so it never ends a run.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_character == MINUS_SIGN) |-> !out_last)
    else $error("minus sign marked as last");

  // Only one value is in work at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second value accepted while busy");

endmodule

bind signed_integer_to_radix_text_top sirt_checker u_sirt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_character  (out_ch.character),
  .out_last       (out_ch.last),
  .out_base_error (out_ch.base_error)
);
